// ===== hdl/cmv_pkg.sv =====
// Package with shared types, constants and helper functions for the convolution unit.
`timescale 1ns / 1ps
package cmv_pkg;
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_KERNELS_DEF  = 16;
    localparam int MAX_KSIZE_DEF    = 5;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_CHANNELS = 3'd2;
    localparam logic [2:0] REG_KERNELS  = 3'd3;
    localparam logic [2:0] REG_KROWS    = 3'd4;
    localparam logic [2:0] REG_KCOLS    = 3'd5;

    localparam logic signed [39:0] SUM_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [39:0] SUM_MIN = -40'sh8000000000;

    typedef enum logic [2:0] {
        t_IDLE, t_SETUP, t_MAC, t_BIAS, t_EMIT
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [10:0] clampv(input logic [10:0] v, input logic [10:0] hi);
        logic [10:0] r;
        if (v == 11'd0) begin
            r = 11'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction
endpackage

// ===== hdl/cmv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/conv2d_multichannel_valid_unit.sv =====
// Top level of the streaming multi-channel valid-mode 2D convolution unit.
`timescale 1ns / 1ps
// A sample that completes a window is followed by one multiply-accumulate per kernel, channel and
// tap on a single shared MAC fed by the line and weight RAMs; o_stall holds off further input
// until the last kernel's sum has been taken past any output stalls, and every other
// transaction is accepted while the unit is idle.
module conv2d_multichannel_valid_unit #(
    parameter int MAX_WIDTH    = cmv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = cmv_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNELS  = cmv_pkg::MAX_KERNELS_DEF,
    parameter int MAX_KSIZE    = cmv_pkg::MAX_KSIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_cmd,
    input  logic [2:0]          i_tap_row,
    input  logic [2:0]          i_tap_col,
    input  logic [3:0]          i_tap_channel,
    input  logic [3:0]          i_kernel_sel,
    input  logic signed [31:0]  i_data_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [9:0]          o_out_row,
    output logic [7:0]          o_out_col,
    output logic [3:0]          o_kernel_index,
    output logic signed [39:0]  o_sum_value,
    output logic                o_last_of_pixel,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int KW = $clog2(MAX_KERNELS) > 0 ? $clog2(MAX_KERNELS) : 1;
    localparam int SW = $clog2(MAX_KSIZE) > 0 ? $clog2(MAX_KSIZE) : 1;
    localparam int LDEPTH = MAX_KSIZE * MAX_WIDTH * MAX_CHANNELS;
    localparam int WDEPTH = MAX_KSIZE * MAX_KSIZE * MAX_CHANNELS * MAX_KERNELS;
    localparam int LAW = $clog2(LDEPTH);
    localparam int WAW = $clog2(WDEPTH);

    logic [8:0]  r_cfg_w;
    logic [10:0] r_cfg_h;
    logic [4:0]  r_cfg_ch, r_cfg_k;
    logic [2:0]  r_cfg_kr, r_cfg_kc;
    logic [9:0]  r_row;
    logic [7:0]  r_col;
    logic [3:0]  r_chan;
    logic [SW-1:0] r_slot;

    cmv_pkg::t_state r_state, n_state;
    logic [3:0]  r_k, r_ch;
    logic [2:0]  r_y, r_x;
    logic [SW-1:0] r_r0s;
    logic [7:0]  r_c0;
    logic signed [39:0] r_acc;
    logic signed [31:0] r_prod;
    logic        r_pv, r_pv2;
    logic signed [31:0] r_bias [MAX_KERNELS];
    logic        r_fin;

    logic [10:0] w_e, h_e, nch_e, nk_e, kr_e, kc_e;
    assign w_e   = cmv_pkg::clampv({2'd0, r_cfg_w}, 11'(MAX_WIDTH < 256 ? MAX_WIDTH : 256));
    assign h_e   = cmv_pkg::clampv(r_cfg_h, 11'd1024);
    assign nch_e = cmv_pkg::clampv({6'd0, r_cfg_ch},
                                   11'(MAX_CHANNELS < 16 ? MAX_CHANNELS : 16));
    assign nk_e  = cmv_pkg::clampv({6'd0, r_cfg_k}, 11'(MAX_KERNELS < 16 ? MAX_KERNELS : 16));
    assign kr_e  = cmv_pkg::clampv({8'd0, r_cfg_kr}, 11'(MAX_KSIZE < 5 ? MAX_KSIZE : 5));
    assign kc_e  = cmv_pkg::clampv({8'd0, r_cfg_kc}, 11'(MAX_KSIZE < 5 ? MAX_KSIZE : 5));

    logic w_acc, w_cfg;
    assign o_stall = (r_state != cmv_pkg::t_IDLE);
    assign w_acc = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == cmv_pkg::t_IDLE);
    assign w_cfg = i_cfg_valid && o_cfg_ready;

    logic w_ld_w, w_ld_b, w_smp, w_win;
    assign w_ld_w = w_acc && i_cmd == cmv_pkg::CMD_WEIGHT && 32'(i_tap_row) < MAX_KSIZE
        && 32'(i_tap_col) < MAX_KSIZE && 32'(i_tap_channel) < MAX_CHANNELS
        && 32'(i_kernel_sel) < MAX_KERNELS;
    assign w_ld_b = w_acc && i_cmd == cmv_pkg::CMD_BIAS && 32'(i_kernel_sel) < MAX_KERNELS;
    assign w_smp  = w_acc && i_cmd == cmv_pkg::CMD_SAMPLE;
    assign w_win  = 11'(r_chan) + 11'd1 >= nch_e && 11'(r_row) + 11'd1 >= kr_e
        && 11'(r_col) + 11'd1 >= kc_e;

    // Line slot of row r0+y, mod MAX_KSIZE.
    logic [SW:0] w_ys;
    logic [SW-1:0] w_slot_rd, w_r0slot;
    logic [2:0] w_back;
    assign w_back = 3'(kr_e - 11'd1);
    always_comb begin
        w_r0slot = (r_slot >= SW'(w_back)) ? SW'(r_slot - SW'(w_back))
                 : SW'((SW+1)'(r_slot) + (SW+1)'(MAX_KSIZE) - (SW+1)'(w_back));
        w_ys = (SW+1)'(r_r0s) + (SW+1)'(r_y);
        w_slot_rd = (w_ys >= (SW+1)'(MAX_KSIZE)) ? SW'(w_ys - (SW+1)'(MAX_KSIZE))
                                                   : SW'(w_ys);
    end

    logic [LAW-1:0] w_laddr_w, w_laddr_r;
    logic [WAW-1:0] w_waddr_w, w_waddr_r;
    logic [7:0] w_cx;
    assign w_cx = r_c0 + 8'(r_x);
    assign w_laddr_w = LAW'((32'(r_slot) * MAX_WIDTH + 32'(r_col)) * MAX_CHANNELS
                            + 32'(r_chan));
    assign w_laddr_r = LAW'((32'(w_slot_rd) * MAX_WIDTH + 32'(w_cx)) * MAX_CHANNELS
                            + 32'(r_ch));
    assign w_waddr_w = WAW'((((32'(i_tap_row) * MAX_KSIZE + 32'(i_tap_col)) * MAX_CHANNELS
                            + 32'(i_tap_channel)) * MAX_KERNELS) + 32'(i_kernel_sel));
    assign w_waddr_r = WAW'((((32'(r_y) * MAX_KSIZE + 32'(r_x)) * MAX_CHANNELS
                            + 32'(r_ch)) * MAX_KERNELS) + 32'(r_k));

    logic [15:0] w_lrd, w_wrd;
    cmv_ram #(.WIDTH(16), .DEPTH(LDEPTH)) u_line (
        .i_clk(i_clk), .i_we(w_smp), .i_waddr(w_laddr_w),
        .i_wdata(cmv_pkg::sat16(i_data_value)), .i_raddr(w_laddr_r), .o_rdata(w_lrd));
    cmv_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight (
        .i_clk(i_clk), .i_we(w_ld_w), .i_waddr(w_waddr_w),
        .i_wdata(cmv_pkg::sat16(i_data_value)), .i_raddr(w_waddr_r), .o_rdata(w_wrd));

    logic w_tap_last;
    assign w_tap_last = 11'(r_x) + 11'd1 >= kc_e && 11'(r_y) + 11'd1 >= kr_e
        && 11'(r_ch) + 11'd1 >= nch_e;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmv_pkg::t_IDLE:  if (w_smp && w_win) n_state = cmv_pkg::t_SETUP;
            cmv_pkg::t_SETUP: n_state = cmv_pkg::t_MAC;
            cmv_pkg::t_MAC:   if (r_fin && !r_pv && !r_pv2) n_state = cmv_pkg::t_BIAS;
            cmv_pkg::t_BIAS:  n_state = cmv_pkg::t_EMIT;
            cmv_pkg::t_EMIT: begin
                if (!i_stall) begin
                    n_state = (11'(r_k) + 11'd1 >= nk_e) ? cmv_pkg::t_IDLE
                                                         : cmv_pkg::t_SETUP;
                end
            end
            default: n_state = cmv_pkg::t_IDLE;
        endcase
    end

    logic signed [40:0] w_biased;
    assign w_biased = 41'(r_acc) + 41'(r_bias[r_k[KW-1:0]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmv_pkg::t_IDLE;
            r_cfg_w <= 9'd128; r_cfg_h <= 11'd128; r_cfg_ch <= 5'd3;
            r_cfg_k <= 5'd16; r_cfg_kr <= 3'd3; r_cfg_kc <= 3'd3;
            r_row <= '0; r_col <= '0; r_chan <= '0; r_slot <= '0;
            r_pv <= 1'b0; r_pv2 <= 1'b0; r_fin <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg) begin
                case (i_cfg_index)
                    cmv_pkg::REG_WIDTH:    r_cfg_w  <= i_cfg_data[8:0];
                    cmv_pkg::REG_HEIGHT:   r_cfg_h  <= i_cfg_data[10:0];
                    cmv_pkg::REG_CHANNELS: r_cfg_ch <= i_cfg_data[4:0];
                    cmv_pkg::REG_KERNELS:  r_cfg_k  <= i_cfg_data[4:0];
                    cmv_pkg::REG_KROWS:    r_cfg_kr <= i_cfg_data[2:0];
                    cmv_pkg::REG_KCOLS:    r_cfg_kc <= i_cfg_data[2:0];
                    default: ;
                endcase
                if (i_cfg_index <= cmv_pkg::REG_KCOLS) begin
                    r_row <= '0; r_col <= '0; r_chan <= '0; r_slot <= '0;
                end
            end
            if (w_smp) begin
                if (w_win) begin
                    r_c0 <= 8'(11'(r_col) + 11'd1 - kc_e);
                    r_k  <= '0;
                end
                if (11'(r_chan) + 11'd1 >= nch_e) begin
                    r_chan <= '0;
                    if (11'(r_col) + 11'd1 >= w_e) begin
                        r_col <= '0;
                        if (11'(r_row) + 11'd1 >= h_e) begin
                            r_row <= '0; r_slot <= '0;
                        end else begin
                            r_row <= r_row + 10'd1;
                            r_slot <= (32'(r_slot) == MAX_KSIZE - 1) ? '0 : r_slot + SW'(1);
                        end
                    end else begin
                        r_col <= r_col + 8'd1;
                    end
                end else begin
                    r_chan <= r_chan + 4'd1;
                end
            end
            if (r_state == cmv_pkg::t_IDLE && w_smp && w_win) begin
                r_r0s <= w_r0slot;
            end
            r_pv <= 1'b0;
            r_pv2 <= r_pv;
            case (r_state)
                cmv_pkg::t_SETUP: begin
                    r_acc <= '0; r_ch <= '0; r_y <= '0; r_x <= '0; r_fin <= 1'b0;
                end
                cmv_pkg::t_MAC: begin
                    if (!r_fin) begin
                        r_pv <= 1'b1;
                        if (w_tap_last) begin
                            r_fin <= 1'b1;
                        end else if (11'(r_x) + 11'd1 >= kc_e) begin
                            r_x <= '0;
                            if (11'(r_y) + 11'd1 >= kr_e) begin
                                r_y <= '0; r_ch <= r_ch + 4'd1;
                            end else begin
                                r_y <= r_y + 3'd1;
                            end
                        end else begin
                            r_x <= r_x + 3'd1;
                        end
                    end
                end
                cmv_pkg::t_BIAS: begin
                    o_valid <= 1'b1;
                    o_kernel_index <= r_k;
                    o_last_of_pixel <= 11'(r_k) + 11'd1 >= nk_e;
                    if (w_biased > 41'(cmv_pkg::SUM_MAX)) begin
                        o_sum_value <= cmv_pkg::SUM_MAX;
                    end else if (w_biased < 41'(cmv_pkg::SUM_MIN)) begin
                        o_sum_value <= cmv_pkg::SUM_MIN;
                    end else begin
                        o_sum_value <= w_biased[39:0];
                    end
                end
                cmv_pkg::t_EMIT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_k <= r_k + 4'd1;
                    end
                end
                default: ;
            endcase
            if (r_pv2) begin
                r_acc <= r_acc + 40'(r_prod);
            end
        end
    end

    logic [9:0] r_orow;
    always_ff @(posedge i_clk) begin
        if (w_smp && w_win && r_state == cmv_pkg::t_IDLE) begin
            r_orow <= 10'(11'(r_row) + 11'd1 - kr_e);
        end
        if (r_pv) begin
            r_prod <= 32'($signed(w_wrd) * $signed(w_lrd));
        end
        if (w_ld_b) begin
            r_bias[i_kernel_sel[KW-1:0]] <= i_data_value;
        end
    end
    assign o_out_row = r_orow;
    assign o_out_col = r_c0;
endmodule
